// ----- design/triangle_assembly_and_face_cull_core_macros.svh -----
// Assertion macros shared by the checker files of the triangle assembly core.
// Depends on nothing; include by bare file name.
`ifndef TRIANGLE_ASSEMBLY_AND_FACE_CULL_CORE_MACROS_SVH
`define TRIANGLE_ASSEMBLY_AND_FACE_CULL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAFC_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("tafc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TAFC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("tafc: next-cycle check failed");

`endif

// ----- design/tafc_pkg.sv -----
// Shared types, codes and helpers of the triangle assembly and face cull core.
// Used by every module of the block; depends on nothing.
package tafc_pkg;

	localparam int COORD_W    = 32;
	localparam int ID_W       = 16;
	localparam int MODE_W     = 2;
	localparam int FACE_W     = 2;
	localparam int ORIENT_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	// Determinant datapath widths: 33x32 signed products, 64-bit minors,
	// and an exact accumulator for three 96-bit terms.
	localparam int HALF_W  = 32;
	localparam int PROD_W  = 65;
	localparam int MINOR_W = 64;
	localparam int DET_W   = 98;

	localparam int MUL_STEPS  = 12;
	localparam int STEP_W     = $clog2(MUL_STEPS + 1);
	localparam int MUL_CODE_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRIMITIVE_MODE  = 3'd0,
		CFG_CULL_ENABLE     = 3'd1,
		CFG_CULL_FACE       = 3'd2,
		CFG_CLOCKWISE_FRONT = 3'd3,
		CFG_TWO_SIDED_LIGHT = 3'd4
	} cfg_index_t;

	localparam logic [MODE_W-1:0] MODE_LIST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STRIP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FAN   = 2'd2;

	localparam logic [FACE_W-1:0] FACE_BACK  = 2'd0;
	localparam logic [FACE_W-1:0] FACE_FRONT = 2'd1;

	localparam logic [ORIENT_W-1:0] ORIENT_ZERO = 2'b00;
	localparam logic [ORIENT_W-1:0] ORIENT_POS  = 2'b01;
	localparam logic [ORIENT_W-1:0] ORIENT_NEG  = 2'b11;

	// One code per multiply of the determinant, in issue order.
	typedef enum logic [MUL_CODE_W-1:0] {
		MUL_BXCY    = 4'd0,
		MUL_BYCX    = 4'd1,
		MUL_BYCW    = 4'd2,
		MUL_BWCY    = 4'd3,
		MUL_BWCX    = 4'd4,
		MUL_BXCW    = 4'd5,
		MUL_M0LO_AW = 4'd6,
		MUL_M0HI_AW = 4'd7,
		MUL_M1LO_AX = 4'd8,
		MUL_M1HI_AX = 4'd9,
		MUL_M2LO_AY = 4'd10,
		MUL_M2HI_AY = 4'd11
	} mul_code_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} tafc_coord_t;

	typedef struct packed {
		logic      clear;
		logic      mul_en;
		mul_code_t code;
	} tafc_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tafc_stat_t;

	// Judge a triangle culled from its orientation and the face registers.
	function automatic logic cull_judge(input logic [FACE_W-1:0] face,
	                                    input logic cw_front,
	                                    input logic [ORIENT_W-1:0] orient);
		logic is_neg;
		logic is_pos;
		is_neg = (orient == ORIENT_NEG);
		is_pos = (orient == ORIENT_POS);
		if (face == FACE_BACK) begin
			cull_judge = is_neg ^ cw_front;
		end else if (face == FACE_FRONT) begin
			cull_judge = is_pos ^ cw_front;
		end else begin
			cull_judge = 1'b1;
		end
	endfunction

endpackage

// ----- design/tafc_mac.sv -----
// Shared multiply-accumulate unit: one 33x32 signed multiplier, a product
// register and one wide adder that builds the minors and the determinant.
// Depends on tafc_pkg.
module tafc_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tafc_pkg::tafc_ctrl_t             ctrl,
	input  tafc_pkg::tafc_coord_t            a,
	input  tafc_pkg::tafc_coord_t            b,
	input  tafc_pkg::tafc_coord_t            c,
	output logic [tafc_pkg::ORIENT_W-1:0]    orientation
);
	import tafc_pkg::*;

	typedef enum logic [1:0] {DST_M0, DST_M1, DST_M2, DST_DET} dst_t;

	logic signed [HALF_W:0]    op_a;
	logic signed [COORD_W-1:0] op_b;
	logic signed [PROD_W-1:0]  prod_s1;
	mul_code_t                 code_s1;
	logic                      valid_s1;
	logic signed [MINOR_W-1:0] m0_q;
	logic signed [MINOR_W-1:0] m1_q;
	logic signed [MINOR_W-1:0] m2_q;
	logic signed [DET_W-1:0]   det_q;
	logic signed [DET_W-1:0]   acc_cur;
	logic signed [DET_W-1:0]   prod_ext;
	logic signed [DET_W-1:0]   addend;
	logic signed [DET_W-1:0]   sum;
	dst_t                      dst;
	logic                      neg;
	logic                      hi;

	// Select multiplier operands for the issued step
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (ctrl.code)
			MUL_BXCY:    begin op_a = {b.x[COORD_W-1], b.x}; op_b = c.y; end
			MUL_BYCX:    begin op_a = {b.y[COORD_W-1], b.y}; op_b = c.x; end
			MUL_BYCW:    begin op_a = {b.y[COORD_W-1], b.y}; op_b = c.w; end
			MUL_BWCY:    begin op_a = {b.w[COORD_W-1], b.w}; op_b = c.y; end
			MUL_BWCX:    begin op_a = {b.w[COORD_W-1], b.w}; op_b = c.x; end
			MUL_BXCW:    begin op_a = {b.x[COORD_W-1], b.x}; op_b = c.w; end
			MUL_M0LO_AW: begin op_a = {1'b0, m0_q[HALF_W-1:0]}; op_b = a.w; end
			MUL_M0HI_AW: begin op_a = {m0_q[MINOR_W-1], m0_q[MINOR_W-1:HALF_W]}; op_b = a.w; end
			MUL_M1LO_AX: begin op_a = {1'b0, m1_q[HALF_W-1:0]}; op_b = a.x; end
			MUL_M1HI_AX: begin op_a = {m1_q[MINOR_W-1], m1_q[MINOR_W-1:HALF_W]}; op_b = a.x; end
			MUL_M2LO_AY: begin op_a = {1'b0, m2_q[HALF_W-1:0]}; op_b = a.y; end
			MUL_M2HI_AY: begin op_a = {m2_q[MINOR_W-1], m2_q[MINOR_W-1:HALF_W]}; op_b = a.y; end
			default:     begin op_a = '0; op_b = '0; end
		endcase
	end

	// Decode where the registered product goes and how it is weighted
	always_comb begin
		dst = DST_DET;
		neg = 1'b0;
		hi  = 1'b0;
		unique case (code_s1) inside
			MUL_BXCY, MUL_BYCX: dst = DST_M0;
			MUL_BYCW, MUL_BWCY: dst = DST_M1;
			MUL_BWCX, MUL_BXCW: dst = DST_M2;
			default:            dst = DST_DET;
		endcase
		neg = (code_s1 == MUL_BYCX) || (code_s1 == MUL_BWCY) || (code_s1 == MUL_BXCW);
		hi  = (code_s1 == MUL_M0HI_AW) || (code_s1 == MUL_M1HI_AX) ||
		      (code_s1 == MUL_M2HI_AY);
	end

	// Shared adder: running value plus the signed, shifted product
	always_comb begin
		unique case (dst)
			DST_M0:  acc_cur = {{(DET_W-MINOR_W){m0_q[MINOR_W-1]}}, m0_q};
			DST_M1:  acc_cur = {{(DET_W-MINOR_W){m1_q[MINOR_W-1]}}, m1_q};
			DST_M2:  acc_cur = {{(DET_W-MINOR_W){m2_q[MINOR_W-1]}}, m2_q};
			default: acc_cur = det_q;
		endcase
		prod_ext = {{(DET_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		if (hi) begin
			prod_ext = prod_ext <<< HALF_W;
		end
		addend = neg ? -prod_ext : prod_ext;
		sum    = acc_cur + addend;
	end

	// Track whether the product register holds a live term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.mul_en;
		end
	end

	// Multiply, then fold the previous product into its accumulator
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		code_s1 <= ctrl.code;
		if (ctrl.clear) begin
			m0_q  <= '0;
			m1_q  <= '0;
			m2_q  <= '0;
			det_q <= '0;
		end else if (valid_s1) begin
			unique case (dst)
				DST_M0:  m0_q  <= sum[MINOR_W-1:0];
				DST_M1:  m1_q  <= sum[MINOR_W-1:0];
				DST_M2:  m2_q  <= sum[MINOR_W-1:0];
				default: det_q <= sum;
			endcase
		end
	end

	// Sign of the finished determinant
	assign orientation = det_q[DET_W-1] ? ORIENT_NEG :
	                     ((det_q == '0) ? ORIENT_ZERO : ORIENT_POS);

endmodule

// ----- design/tafc_seq.sv -----
// Step sequencer of the determinant: walks the twelve multiplies, lets the
// last product settle, then holds the result until the top level retires it.
// Depends on tafc_pkg.
module tafc_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 retire,
	output tafc_pkg::tafc_ctrl_t ctrl,
	output tafc_pkg::tafc_stat_t stat
);
	import tafc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;

	// Advance through the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						cnt_q   <= '0;
					end
				end
				S_RUN: begin
					if (cnt_q == STEP_W'(MUL_STEPS)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (retire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Drive the shared unit
	always_comb begin
		ctrl.clear  = (state_q == S_IDLE) && start;
		ctrl.mul_en = (state_q == S_RUN) && (cnt_q < STEP_W'(MUL_STEPS));
		ctrl.code   = mul_code_t'(cnt_q[MUL_CODE_W-1:0]);
		stat.busy   = (state_q != S_IDLE);
		stat.done   = (state_q == S_DONE);
	end

endmodule

// ----- design/triangle_assembly_and_face_cull_core.sv -----
// Triangle assembly and face cull core: takes one vertex word at a time and
// builds separate triangles, strips or fans from them; for each triangle it
// finds the exact sign of the (w, x, y) determinant and culls or emits it
// with a back-color flag. Depends on tafc_pkg, tafc_seq and tafc_mac.
// A vertex that completes no triangle is taken whenever no triangle is in
// work. A vertex that completes a triangle holds vertex_stall high while a
// single 33x32 multiplier works through six minor products and six partial
// products, one per cycle; a finished triangle that waits on a full, stalled
// output register keeps vertex_stall high longer.
// A culled triangle under cull_enable produces no output word. Configuration
// writes are taken in any cycle and belong only in idle periods.
module triangle_assembly_and_face_cull_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// vertex channel
	input  logic                                vertex_valid,
	output logic                                vertex_stall,
	input  logic                                restart,
	input  logic [tafc_pkg::ID_W-1:0]           vertex_id,
	input  logic signed [tafc_pkg::COORD_W-1:0] clip_x,
	input  logic signed [tafc_pkg::COORD_W-1:0] clip_y,
	input  logic signed [tafc_pkg::COORD_W-1:0] clip_w,
	// triangle channel
	output logic                                tri_valid,
	input  logic                                tri_stall,
	output logic [tafc_pkg::ID_W-1:0]           first_vertex,
	output logic [tafc_pkg::ID_W-1:0]           second_vertex,
	output logic [tafc_pkg::ID_W-1:0]           third_vertex,
	output logic                                use_back_color,
	output logic signed [tafc_pkg::ORIENT_W-1:0] orientation,
	// configuration
	input  logic                                cfg_we,
	input  logic [tafc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tafc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tafc_pkg::*;

	logic [MODE_W-1:0]   mode_q;
	logic                cull_en_q;
	logic [FACE_W-1:0]   face_q;
	logic                cw_front_q;
	logic                two_sided_q;

	logic [ID_W-1:0]     held_id_q [2];
	tafc_coord_t         held_q    [2];
	logic [1:0]          phase_q;
	logic                odd_q;

	tafc_coord_t         a_q;
	tafc_coord_t         b_q;
	tafc_coord_t         c_q;
	logic [ID_W-1:0]     a_id_q;
	logic [ID_W-1:0]     b_id_q;
	logic [ID_W-1:0]     c_id_q;

	logic                out_valid_q;
	logic [ID_W-1:0]     first_q;
	logic [ID_W-1:0]     second_q;
	logic [ID_W-1:0]     third_q;
	logic                back_q;
	logic [ORIENT_W-1:0] orient_q;

	tafc_coord_t         vin;
	tafc_ctrl_t          ctrl;
	tafc_stat_t          stat;
	logic [ORIENT_W-1:0] det_orient;
	logic                accept;
	logic                is_first;
	logic                is_second;
	logic                start;
	logic                swap;
	logic                culled;
	logic                drop;
	logic                out_free;
	logic                retire;

	assign vin.w = clip_w;
	assign vin.x = clip_x;
	assign vin.y = clip_y;

	// Accept vertices whenever no triangle is in work
	assign vertex_stall = stat.busy;
	assign accept       = vertex_valid && !stat.busy;
	assign is_first     = restart || (phase_q == 2'd0);
	assign is_second    = !is_first && (phase_q == 2'd1);
	assign start        = accept && !is_first && !is_second;
	assign swap         = (mode_q == MODE_STRIP) && odd_q;

	// Finish: drop or move the triangle into the output register
	assign culled   = cull_judge(face_q, cw_front_q, det_orient);
	assign drop     = cull_en_q && culled;
	assign out_free = !out_valid_q || !tri_stall;
	assign retire   = stat.done && (drop || out_free);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_LIST;
			cull_en_q   <= 1'b0;
			face_q      <= FACE_BACK;
			cw_front_q  <= 1'b0;
			two_sided_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRIMITIVE_MODE:  mode_q      <= cfg_data[MODE_W-1:0];
				CFG_CULL_ENABLE:     cull_en_q   <= cfg_data[0];
				CFG_CULL_FACE:       face_q      <= cfg_data[FACE_W-1:0];
				CFG_CLOCKWISE_FRONT: cw_front_q  <= cfg_data[0];
				CFG_TWO_SIDED_LIGHT: two_sided_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Assemble: keep held vertices, phase and strip parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 2'd0;
			odd_q        <= 1'b0;
			held_id_q[0] <= '0;
			held_id_q[1] <= '0;
			held_q[0]    <= '0;
			held_q[1]    <= '0;
		end else if (accept) begin
			if (is_first) begin
				held_id_q[0] <= vertex_id;
				held_q[0]    <= vin;
				phase_q      <= 2'd1;
				if (restart) begin
					odd_q <= 1'b0;
				end
			end else if (is_second) begin
				held_id_q[1] <= vertex_id;
				held_q[1]    <= vin;
				phase_q      <= 2'd2;
			end else begin
				unique case (mode_q)
					MODE_STRIP: begin
						held_id_q[0] <= held_id_q[1];
						held_q[0]    <= held_q[1];
						held_id_q[1] <= vertex_id;
						held_q[1]    <= vin;
						odd_q        <= !odd_q;
					end
					MODE_FAN: begin
						held_id_q[1] <= vertex_id;
						held_q[1]    <= vin;
					end
					default: phase_q <= 2'd0;
				endcase
			end
		end
	end

	// Latch the triangle in emitted order for the determinant
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= swap ? held_q[1] : held_q[0];
			b_q    <= swap ? held_q[0] : held_q[1];
			c_q    <= vin;
			a_id_q <= swap ? held_id_q[1] : held_id_q[0];
			b_id_q <= swap ? held_id_q[0] : held_id_q[1];
			c_id_q <= vertex_id;
		end
	end

	tafc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.retire (retire),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	tafc_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.a           (a_q),
		.b           (b_q),
		.c           (c_q),
		.orientation (det_orient)
	);

	// Output register: load a kept triangle, clear when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && !drop) begin
			out_valid_q <= 1'b1;
		end else if (!tri_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && !drop) begin
			first_q  <= a_id_q;
			second_q <= b_id_q;
			third_q  <= c_id_q;
			back_q   <= two_sided_q && culled;
			orient_q <= det_orient;
		end
	end

	assign tri_valid      = out_valid_q;
	assign first_vertex   = first_q;
	assign second_vertex  = second_q;
	assign third_vertex   = third_q;
	assign use_back_color = back_q;
	assign orientation    = orient_q;

endmodule

// ----- design/tafc_checker.sv -----
// Port-level checks of the triangle assembly core, bound to the top level.
// Depends on tafc_pkg and the shared assertion macro header.
`include "triangle_assembly_and_face_cull_core_macros.svh"

module tafc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                vertex_valid,
	input logic                                vertex_stall,
	input logic                                restart,
	input logic                                tri_valid,
	input logic                                tri_stall,
	input logic [tafc_pkg::ID_W-1:0]           first_vertex,
	input logic [tafc_pkg::ID_W-1:0]           second_vertex,
	input logic [tafc_pkg::ID_W-1:0]           third_vertex,
	input logic                                use_back_color,
	input logic [tafc_pkg::ORIENT_W-1:0]       orientation
);
	import tafc_pkg::*;

	// A stalled output word stays valid and unchanged
	`TAFC_ASSERT_NEXT(a_tri_hold, clk, arst_n, tri_valid && tri_stall, tri_valid)
	`TAFC_ASSERT_NEXT(a_tri_stable, clk, arst_n, tri_valid && tri_stall, $stable(first_vertex) && $stable(second_vertex) && $stable(third_vertex) && $stable(use_back_color) && $stable(orientation))

	// A valid output word always carries a sign code as its orientation
	`TAFC_ASSERT_IMPL(a_orient_code, clk, arst_n, tri_valid, orientation == ORIENT_NEG || orientation == ORIENT_ZERO || orientation == ORIENT_POS)

	// A new triangle only appears after a stretch of determinant work
	`TAFC_ASSERT_IMPL(a_tri_after_work, clk, arst_n, $rose(tri_valid), $past(vertex_stall))

	// A restart vertex never starts a triangle
	`TAFC_ASSERT_NEXT(a_restart_free, clk, arst_n, vertex_valid && !vertex_stall && restart, !vertex_stall)

endmodule

bind triangle_assembly_and_face_cull_core tafc_checker u_tafc_checker (.*);
